// ----- rtl/core/msas_pkg.sv -----
// Shared constants, types and command structures for the assignment solver.
`default_nettype none
package msas_pkg;
    localparam int MAX_SIZE = 16;
    localparam int SLOTS    = MAX_SIZE + 1;
    localparam int IDX_W    = $clog2(SLOTS);
    localparam int DEPTH    = MAX_SIZE * MAX_SIZE;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int POS_W    = $clog2(DEPTH + 2);
    localparam int SIZE_W   = 5;
    localparam int COST_W   = 16;
    localparam int POT_W    = 22;
    localparam int RES_W    = 20;
    localparam int OUT_W    = 24;

    // Scan token that walks the column chain
    typedef struct packed {
        logic                    valid;
        logic                    min_inf;
        logic signed [POT_W-1:0] min_val;
        logic [IDX_W-1:0]        arg;
        logic [IDX_W-1:0]        cur;
        logic signed [POT_W-1:0] rp;
    } token_t;

    // Broadcast commands from the sequencer to every cell
    typedef struct packed {
        logic                    clr;
        logic                    row_init;
        logic                    mark;
        logic                    upd;
        logic                    aug;
        logic [IDX_W-1:0]        sel;
        logic [IDX_W-1:0]        owner;
        logic signed [POT_W-1:0] rp;
        logic signed [POT_W-1:0] delta;
    } cell_cmd_t;

    // State a cell shows to the sequencer
    typedef struct packed {
        logic [IDX_W-1:0]        owner;
        logic [IDX_W-1:0]        back;
        logic signed [POT_W-1:0] rp;
        logic signed [POT_W-1:0] cp;
    } cell_view_t;
endpackage
`default_nettype wire

// ----- rtl/core/msas_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module msas_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ----- rtl/core/msas_cell.sv -----
// One column slot of the solver chain: potentials, slack, marks and links.
`default_nettype none
module msas_cell (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic [msas_pkg::IDX_W-1:0] cell_idx,
    input  wire logic [msas_pkg::IDX_W-1:0] n_active,
    input  wire msas_pkg::cell_cmd_t        cmd,
    input  wire logic [msas_pkg::COST_W-1:0] cost_in,
    input  wire msas_pkg::token_t           tok_in,
    output msas_pkg::token_t                tok_out,
    output msas_pkg::cell_view_t            view
);
    import msas_pkg::*;

    logic                    used_reg;
    logic                    inf_reg;
    logic signed [POT_W-1:0] slack_reg;
    logic signed [POT_W-1:0] cp_reg;
    logic signed [POT_W-1:0] rp_reg;
    logic [IDX_W-1:0]        owner_reg;
    logic [IDX_W-1:0]        back_reg;
    token_t                  tok_reg;
    token_t                  tok_next;

    logic                    enabled;
    logic                    scan;
    logic signed [POT_W+1:0] red_wide;
    logic signed [POT_W-1:0] reduced;
    logic                    take;
    logic signed [POT_W-1:0] new_slack;
    logic                    better;

    assign enabled  = (cell_idx != '0) && (cell_idx <= n_active);
    assign scan     = tok_in.valid && enabled && !used_reg;
    assign red_wide = $signed({{(POT_W+2-COST_W){1'b0}}, cost_in})
                    - $signed({{2{tok_in.rp[POT_W-1]}}, tok_in.rp})
                    - $signed({{2{cp_reg[POT_W-1]}}, cp_reg});
    assign reduced   = red_wide[POT_W-1:0];
    assign take      = inf_reg || (reduced < slack_reg);
    assign new_slack = take ? reduced : slack_reg;
    assign better    = tok_in.min_inf || (new_slack < tok_in.min_val);

    always_comb begin
        tok_next = tok_in;
        if (scan && better) begin
            tok_next.min_inf = 1'b0;
            tok_next.min_val = new_slack;
            tok_next.arg     = cell_idx;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg <= '0;
        end else begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.clr) begin
            rp_reg    <= '0;
            cp_reg    <= '0;
            owner_reg <= '0;
            back_reg  <= '0;
        end
        if (cmd.row_init) begin
            inf_reg  <= 1'b1;
            used_reg <= 1'b0;
            if (cell_idx == '0) begin
                owner_reg <= cmd.owner;
                rp_reg    <= '0;
            end
        end
        if (cmd.mark && (cmd.sel == cell_idx)) begin
            used_reg <= 1'b1;
        end
        if (scan && take) begin
            slack_reg <= reduced;
            inf_reg   <= 1'b0;
            back_reg  <= tok_in.cur;
        end
        if (cmd.upd) begin
            if (used_reg) begin
                rp_reg <= rp_reg + cmd.delta;
                cp_reg <= cp_reg - cmd.delta;
            end else if (!inf_reg) begin
                slack_reg <= slack_reg - cmd.delta;
            end
        end
        if (cmd.aug && (cmd.sel == cell_idx)) begin
            owner_reg <= cmd.owner;
            rp_reg    <= cmd.rp;
        end
    end

    assign tok_out    = tok_reg;
    assign view.owner = owner_reg;
    assign view.back  = back_reg;
    assign view.rp    = rp_reg;
    assign view.cp    = cp_reg;
endmodule
`default_nettype wire

// ----- rtl/core/min_cost_assignment_solver_unit.sv -----
// Top level of the assignment solver: loader, solve sequencer and cell chain.
//
//  channel | direction | payload (low bit up)               | handshake
//  s_      | in        | tdata: cost[15:0]; tlast: last elt | s_tvalid/s_tready
//  m_      | out       | tdata: min_cost[19:0]; tuser: err  | m_tvalid/m_tready
//  cfg_    | in        | cfg_wdata: matrix_size[4:0]        | cfg_we, no wait
//
// Loading takes one beat per cycle unless a last beat waits on an older result.
// A solve runs a clear state, then per row an init state; per step of the
// column search a mark, the scan token rippling through all MAX_SIZE+1 column
// cells behind the cost read, and the update; the augmenting walk link by link,
// then ST_FINISH. An error result is posted in the cycle after the last beat.
// Reset clears the handshake and sequencer state; the cost store needs no
// clearing. A stalled result beat holds while the next matrix loads.
`default_nettype none
module min_cost_assignment_solver_unit (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_we,
    input  wire logic [msas_pkg::SIZE_W-1:0]  cfg_wdata,  // matrix_size
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [msas_pkg::COST_W-1:0]  s_tdata,    // cost
    input  wire logic                         s_tlast,    // last_element
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [msas_pkg::OUT_W-1:0]        m_tdata,    // min_cost, zero pad
    output logic                              m_tuser     // load_error
);
    import msas_pkg::*;

    typedef enum logic [7:0] {
        ST_LOAD   = 8'b0000_0001,
        ST_CLEAR  = 8'b0000_0010,
        ST_ROW    = 8'b0000_0100,
        ST_STEP   = 8'b0000_1000,
        ST_SCAN   = 8'b0001_0000,
        ST_UPDATE = 8'b0010_0000,
        ST_AUG    = 8'b0100_0000,
        ST_FINISH = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [SIZE_W-1:0]       size_reg;
    logic [IDX_W-1:0]        n_load;
    logic [IDX_W-1:0]        n_reg, n_next;
    logic [POS_W-1:0]        count;
    logic [POS_W-1:0]        pos_reg, pos_next, pos_inc;
    logic [IDX_W-1:0]        row_reg, row_next;
    logic [IDX_W-1:0]        cur_reg, cur_next;
    logic [IDX_W-1:0]        arg_reg, arg_next;
    logic [IDX_W-1:0]        k_reg, k_next;
    logic                    launch_reg, launch_next;
    logic [ADDR_W-1:0]       base_reg, base_next;
    logic signed [POT_W-1:0] delta_reg, delta_next;
    logic signed [POT_W-1:0] steprp_reg, steprp_next;
    logic                    out_valid_reg, out_valid_next;
    logic [RES_W-1:0]        out_cost_reg, out_cost_next;
    logic                    out_err_reg, out_err_next;

    token_t                  tok0_reg, tok0_next;
    token_t                  tok_chain [0:SLOTS];
    cell_view_t              views [0:SLOTS-1];
    cell_cmd_t               cmd;

    logic                    in_beat;
    logic                    ram_we;
    logic [ADDR_W-1:0]       ram_raddr;
    logic [COST_W-1:0]       ram_rdata;
    logic [IDX_W-1:0]        step_owner;
    logic [IDX_W-1:0]        aug_prev;
    logic [2*IDX_W-1:0]      base_prod;
    logic signed [POT_W-1:0] neg_cp0;
    logic [RES_W-1:0]        result;

    // Clamp the size: zero runs as one, oversize saturates.
    always_comb begin
        if (size_reg == '0) begin
            n_load = IDX_W'(1);
        end else if (size_reg > SIZE_W'(MAX_SIZE)) begin
            n_load = IDX_W'(MAX_SIZE);
        end else begin
            n_load = IDX_W'(size_reg);
        end
    end

    assign count   = POS_W'(n_load) * POS_W'(n_load);
    assign pos_inc = pos_reg + POS_W'(1);

    // Hold off a last beat while an earlier result still waits.
    assign s_tready = (state_reg == ST_LOAD) && !(out_valid_reg && s_tlast);
    assign in_beat  = s_tvalid && s_tready;
    assign ram_we   = in_beat && (pos_reg < count);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg <= SIZE_W'(MAX_SIZE);
        end else if (cfg_we) begin
            size_reg <= cfg_wdata;
        end
    end

    msas_ram #(
        .WIDTH (COST_W),
        .DEPTH (DEPTH)
    ) u_cost_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (pos_reg[ADDR_W-1:0]),
        .wdata (s_tdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Address runs ahead of the token by the registered read so each cell sees its own column.
    assign ram_raddr = base_reg + ADDR_W'(k_reg) - ADDR_W'(1);

    // Column chain: the token enters at slot 0 and leaves past the last slot.
    assign tok_chain[0] = tok0_reg;

    for (genvar c = 0; c < SLOTS; c++) begin : g_cell
        msas_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cell_idx (IDX_W'(c)),
            .n_active (n_reg),
            .cmd      (cmd),
            .cost_in  (ram_rdata),
            .tok_in   (tok_chain[c]),
            .tok_out  (tok_chain[c+1]),
            .view     (views[c])
        );
    end

    assign step_owner = views[cur_reg].owner;
    assign aug_prev   = views[cur_reg].back;
    assign base_prod  = (step_owner - IDX_W'(1)) * n_reg;
    assign neg_cp0    = -views[0].cp;

    always_comb begin
        if (neg_cp0 < 0) begin
            result = '0;
        end else if (neg_cp0 > $signed(POT_W'({RES_W{1'b1}}))) begin
            result = '1;
        end else begin
            result = neg_cp0[RES_W-1:0];
        end
    end

    always_comb begin
        state_next     = state_reg;
        n_next         = n_reg;
        pos_next       = pos_reg;
        row_next       = row_reg;
        cur_next       = cur_reg;
        arg_next       = arg_reg;
        k_next         = k_reg;
        launch_next    = 1'b0;
        base_next      = base_reg;
        delta_next     = delta_reg;
        steprp_next    = steprp_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_cost_next  = out_cost_reg;
        out_err_next   = out_err_reg;
        tok0_next      = '0;
        cmd            = '0;

        unique case (state_reg)
            ST_LOAD: begin
                if (in_beat) begin
                    if (pos_reg <= count) begin
                        pos_next = pos_inc;
                    end
                    if (s_tlast) begin
                        pos_next = '0;
                        if (((pos_reg <= count) ? pos_inc : pos_reg) == count) begin
                            n_next     = n_load;
                            state_next = ST_CLEAR;
                        end else begin
                            out_valid_next = 1'b1;
                            out_cost_next  = '0;
                            out_err_next   = 1'b1;
                        end
                    end
                end
            end
            ST_CLEAR: begin
                cmd.clr    = 1'b1;
                row_next   = IDX_W'(1);
                state_next = ST_ROW;
            end
            ST_ROW: begin
                cmd.row_init = 1'b1;
                cmd.owner    = row_reg;
                cur_next     = '0;
                state_next   = ST_STEP;
            end
            ST_STEP: begin
                cmd.mark    = 1'b1;
                cmd.sel     = cur_reg;
                base_next   = base_prod[ADDR_W-1:0];
                steprp_next = views[cur_reg].rp;
                k_next      = '0;
                launch_next = 1'b1;
                state_next  = ST_SCAN;
            end
            ST_SCAN: begin
                if (k_reg < n_reg) begin
                    k_next = k_reg + IDX_W'(1);
                end
                if (launch_reg) begin
                    tok0_next.valid   = 1'b1;
                    tok0_next.min_inf = 1'b1;
                    tok0_next.cur     = cur_reg;
                    tok0_next.rp      = steprp_reg;
                end
                if (tok_chain[SLOTS].valid) begin
                    delta_next = tok_chain[SLOTS].min_inf ? '0 : tok_chain[SLOTS].min_val;
                    arg_next   = tok_chain[SLOTS].arg;
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                cmd.upd   = 1'b1;
                cmd.delta = delta_reg;
                cur_next  = arg_reg;
                if (views[arg_reg].owner == '0) begin
                    state_next = ST_AUG;
                end else begin
                    state_next = ST_STEP;
                end
            end
            ST_AUG: begin
                // Shift ownership one link back along the alternating path.
                cmd.aug   = 1'b1;
                cmd.sel   = cur_reg;
                cmd.owner = views[aug_prev].owner;
                cmd.rp    = views[aug_prev].rp;
                cur_next  = aug_prev;
                if (aug_prev == '0) begin
                    if (row_reg == n_reg) begin
                        state_next = ST_FINISH;
                    end else begin
                        row_next   = row_reg + IDX_W'(1);
                        state_next = ST_ROW;
                    end
                end
            end
            ST_FINISH: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_cost_next  = result;
                    out_err_next   = 1'b0;
                    state_next     = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_LOAD;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
            launch_reg    <= 1'b0;
            tok0_reg      <= '0;
        end else begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
            launch_reg    <= launch_next;
            tok0_reg      <= tok0_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg        <= n_next;
        row_reg      <= row_next;
        cur_reg      <= cur_next;
        arg_reg      <= arg_next;
        k_reg        <= k_next;
        base_reg     <= base_next;
        delta_reg    <= delta_next;
        steprp_reg   <= steprp_next;
        out_cost_reg <= out_cost_next;
        out_err_reg  <= out_err_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_W-RES_W){1'b0}}, out_cost_reg};
    assign m_tuser  = out_err_reg;
endmodule
`default_nettype wire

// ----- rtl/core/msas_checker.sv -----
// Port-level checker for the assignment solver, bound to the top level.
`default_nettype none
module msas_checker (
    input wire logic                         aclk,
    input wire logic                         aresetn,
    input wire logic                         s_tvalid,
    input wire logic                         s_tready,
    input wire logic                         s_tlast,
    input wire logic                         m_tvalid,
    input wire logic                         m_tready,
    input wire logic [msas_pkg::OUT_W-1:0]   m_tdata,
    input wire logic                         m_tuser
);
    import msas_pkg::*;

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result beat changed");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("load error beat carries nonzero cost");

    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && s_tvalid && s_tlast |-> !s_tready)
        else $error("last beat taken while a result waits");

    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[OUT_W-1:RES_W] == '0)
        else $error("result padding not zero");
endmodule

bind min_cost_assignment_solver_unit msas_checker u_msas_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire
